@@ design/x86d_pkg.sv @@
// Shared types, codes and opcode decode functions for the 8086 instruction decoder.
package x86d_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int START_W         = 20;

    typedef enum logic [2:0] {
        K_MOV     = 3'd0,
        K_ADD     = 3'd1,
        K_SUB     = 3'd2,
        K_CMP     = 3'd3,
        K_JCC     = 3'd4,
        K_LOOP    = 3'd5,
        K_ILLEGAL = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        F_RM_REG     = 3'd0,
        F_IMM_RM     = 3'd1,
        F_IMM_REG    = 3'd2,
        F_ACC_MEM    = 3'd3,
        F_IMM_ACC    = 3'd4,
        F_SHORT_JUMP = 3'd5
    } t_form;

    // Operation codes carried in the reg field of the 80..83 immediate group.
    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_SUB = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd7;

    localparam logic [5:0] OP_GRP_IMM = 6'b100000;

    typedef struct packed {
        t_kind kind;
        t_form form;
    } t_class;

    typedef struct packed {
        logic [2:0]         op_kind;
        logic [2:0]         form;
        logic [3:0]         condition;
        logic               wide;
        logic               to_reg;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic [15:0]        displacement;
        logic [15:0]        immediate;
        logic [START_W-1:0] start_offset;
        logic [2:0]         length;
    } t_result;

    function automatic t_class classify(input logic [7:0] op);
        t_class c;
        c.kind = K_ILLEGAL;
        c.form = F_RM_REG;
        case (op) inside
            8'b1000_10??: c.kind = K_MOV;
            8'b1100_011?: begin c.kind = K_MOV; c.form = F_IMM_RM;     end
            8'b1011_????: begin c.kind = K_MOV; c.form = F_IMM_REG;    end
            8'b1010_00??: begin c.kind = K_MOV; c.form = F_ACC_MEM;    end
            8'b0000_00??: c.kind = K_ADD;
            8'b0010_10??: c.kind = K_SUB;
            8'b0011_10??: c.kind = K_CMP;
            8'b1000_00??: begin c.kind = K_ADD; c.form = F_IMM_RM;     end
            8'b0000_010?: begin c.kind = K_ADD; c.form = F_IMM_ACC;    end
            8'b0010_110?: begin c.kind = K_SUB; c.form = F_IMM_ACC;    end
            8'b0011_110?: begin c.kind = K_CMP; c.form = F_IMM_ACC;    end
            8'b0111_????: begin c.kind = K_JCC; c.form = F_SHORT_JUMP; end
            8'b1110_00??: begin c.kind = K_LOOP; c.form = F_SHORT_JUMP; end
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] disp_count(input t_form form, input logic [7:0] modrm);
        logic [1:0] n;
        n = 2'd0;
        case (form)
            F_ACC_MEM:    n = 2'd2;
            F_SHORT_JUMP: n = 2'd1;
            F_RM_REG, F_IMM_RM: begin
                case (modrm[7:6])
                    2'b01:   n = 2'd1;
                    2'b10:   n = 2'd2;
                    2'b00:   n = (modrm[2:0] == 3'b110) ? 2'd2 : 2'd0;
                    default: n = 2'd0;
                endcase
            end
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] imm_count(input logic [7:0] op, input t_form form);
        logic [1:0] n;
        n = 2'd0;
        case (form)
            F_IMM_RM: begin
                if (op[7:2] == OP_GRP_IMM) begin
                    n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
                end else begin
                    n = 2'd1 + {1'b0, op[0]};
                end
            end
            F_IMM_REG: n = 2'd1 + {1'b0, op[3]};
            F_IMM_ACC: n = 2'd1 + {1'b0, op[0]};
            default:   n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/x86_16_instruction_decoder.sv @@
// Byte-serial 8086 instruction decoder: length tracking, field collection and record output.
//
// Usage: the code stream enters one byte per beat on i_valid/o_stall with the
// byte on i_code_byte. Each byte updates a small position state (byte count,
// expected length, collected opcode, addressing byte, displacement and
// immediate). The beat that carries an instruction's last byte loads one
// decoded record into the output register, shown on o_valid with the fields
// on the o_ ports; the receiver holds it with i_stall.
// The record is registered: it appears in the cycle after its last byte is accepted.
// One byte is taken per cycle while o_stall is low; an instruction has 1 to 6
// bytes, and the rate is set by the single byte-wide input port.
// A new byte is taken while a record waits, as long as that record is either
// being taken in the same cycle or the output register is empty. While a
// record is held by i_stall, o_stall is raised and the input waits.
// Reset (i_rst_n low, synchronous) empties the output register, returns the
// decoder to the awaiting-opcode position and zeroes the stream offset.
// Unknown opcodes yield an illegal record of length 1.
module x86_16_instruction_decoder #(
    parameter int OFFSET_BITS = x86d_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_code_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_op_kind,
    output logic [2:0]                    o_form,
    output logic [3:0]                    o_condition,
    output logic                          o_wide,
    output logic                          o_to_reg,
    output logic [1:0]                    o_mode,
    output logic [2:0]                    o_reg_field,
    output logic [2:0]                    o_rm_field,
    output logic [15:0]                   o_displacement,
    output logic [15:0]                   o_immediate,
    output logic [x86d_pkg::START_W-1:0]  o_start_offset,
    output logic [2:0]                    o_length
);
    import x86d_pkg::*;

    logic [2:0]             r_index;
    logic [2:0]             r_needed;
    logic [7:0]             r_opcode;
    logic [7:0]             r_modrm;
    logic [15:0]            r_disp;
    logic [15:0]            r_imm;
    logic [OFFSET_BITS-1:0] r_stream;
    logic [OFFSET_BITS-1:0] r_instr_start;
    logic                   r_out_valid;
    t_result                r_out;

    logic [2:0]             n_index;
    logic [2:0]             n_needed;
    logic [7:0]             n_opcode;
    logic [7:0]             n_modrm;
    logic [15:0]            n_disp;
    logic [15:0]            n_imm;
    logic [OFFSET_BITS-1:0] n_instr_start;
    t_result                n_out;

    logic                   accept;
    logic                   first;
    logic                   hdr_two;
    logic                   done;
    t_class                 cls;
    logic [2:0]             pos;
    logic [2:0]             imm_pos;
    logic [1:0]             dn;
    logic [1:0]             dn_out;
    logic [3:0]             next_count;
    logic [15:0]            disp_out;
    logic [15:0]            imm_out;
    logic [2:0]             reg_out;
    t_kind                  kind_out;
    logic [OFFSET_BITS+START_W-1:0] start_ext;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        first         = (r_index == 3'd0);
        n_opcode      = first ? i_code_byte : r_opcode;
        n_modrm       = first ? 8'd0 : r_modrm;
        n_disp        = first ? 16'd0 : r_disp;
        n_imm         = first ? 16'd0 : r_imm;
        n_instr_start = first ? r_stream : r_instr_start;
        n_needed      = r_needed;
        cls           = classify(n_opcode);
        hdr_two       = (cls.form == F_RM_REG) || (cls.form == F_IMM_RM);
        pos           = r_index - (hdr_two ? 3'd2 : 3'd1);
        dn            = disp_count(cls.form, r_modrm);
        imm_pos       = pos - {1'b0, dn};

        if (first) begin
            n_needed = hdr_two ? 3'd2
                     : 3'd1 + {1'b0, disp_count(cls.form, 8'd0)}
                            + {1'b0, imm_count(n_opcode, cls.form)};
        end else if (r_index == 3'd1 && hdr_two) begin
            n_modrm  = i_code_byte;
            n_needed = 3'd2 + {1'b0, disp_count(cls.form, i_code_byte)}
                            + {1'b0, imm_count(n_opcode, cls.form)};
        end else if (pos < {1'b0, dn}) begin
            if (pos[0]) begin
                n_disp[15:8] = n_disp[15:8] | i_code_byte;
            end else begin
                n_disp[7:0] = n_disp[7:0] | i_code_byte;
            end
        end else begin
            if (imm_pos[0]) begin
                n_imm[15:8] = n_imm[15:8] | i_code_byte;
            end else begin
                n_imm[7:0] = n_imm[7:0] | i_code_byte;
            end
        end

        next_count = {1'b0, r_index} + 4'd1;
        if (cls.kind == K_ILLEGAL && cls.form == F_RM_REG) begin
            n_needed = 3'd1;
            done     = 1'b1;
        end else begin
            done = !((next_count < {1'b0, n_needed}) && (r_index < 3'd5));
        end
        n_index = done ? 3'd0 : next_count[2:0];
    end

    // Record assembly from the state as it stands after this byte.
    always_comb begin
        dn_out    = disp_count(cls.form, n_modrm);
        disp_out  = n_disp;
        imm_out   = n_imm;
        kind_out  = cls.kind;
        reg_out   = n_modrm[5:3];
        start_ext = {{START_W{1'b0}}, n_instr_start};

        if (dn_out == 2'd1 && n_disp[7]) begin
            disp_out[15:8] = 8'hFF;
        end
        if (cls.form == F_IMM_RM && n_opcode[7:2] == OP_GRP_IMM) begin
            case (reg_out)
                GRP_ADD: kind_out = K_ADD;
                GRP_SUB: kind_out = K_SUB;
                GRP_CMP: kind_out = K_CMP;
                default: kind_out = K_ILLEGAL;
            endcase
            if (n_opcode[1:0] == 2'b11 && n_imm[7]) begin
                imm_out[15:8] = 8'hFF;
            end
        end

        n_out              = '0;
        n_out.op_kind      = kind_out;
        n_out.start_offset = start_ext[START_W-1:0];
        n_out.length       = next_count[2:0];
        if (!(cls.kind == K_ILLEGAL && cls.form == F_RM_REG)) begin
            n_out.form         = cls.form;
            n_out.displacement = disp_out;
            n_out.immediate    = imm_out;
            case (cls.form)
                F_RM_REG, F_IMM_RM: begin
                    n_out.mode      = n_modrm[7:6];
                    n_out.reg_field = reg_out;
                    n_out.rm_field  = n_modrm[2:0];
                    n_out.wide      = n_opcode[0];
                    n_out.to_reg    = (cls.form == F_RM_REG) ? n_opcode[1] : 1'b0;
                end
                F_IMM_REG: begin
                    n_out.wide      = n_opcode[3];
                    n_out.reg_field = n_opcode[2:0];
                end
                F_ACC_MEM: begin
                    n_out.wide   = n_opcode[0];
                    n_out.to_reg = ~n_opcode[1];
                end
                F_IMM_ACC: n_out.wide = n_opcode[0];
                F_SHORT_JUMP: begin
                    n_out.condition = (cls.kind == K_JCC) ? n_opcode[3:0]
                                                          : {2'b00, n_opcode[1:0]};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index       <= 3'd0;
            r_needed      <= 3'd0;
            r_opcode      <= 8'd0;
            r_modrm       <= 8'd0;
            r_disp        <= 16'd0;
            r_imm         <= 16'd0;
            r_stream      <= '0;
            r_instr_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_index       <= n_index;
                r_needed      <= n_needed;
                r_opcode      <= n_opcode;
                r_modrm       <= n_modrm;
                r_disp        <= n_disp;
                r_imm         <= n_imm;
                r_stream      <= r_stream + OFFSET_BITS'(1);
                r_instr_start <= n_instr_start;
            end
            if (accept && done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The record register carries payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept && done) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_op_kind      = r_out.op_kind;
    assign o_form         = r_out.form;
    assign o_condition    = r_out.condition;
    assign o_wide         = r_out.wide;
    assign o_to_reg       = r_out.to_reg;
    assign o_mode         = r_out.mode;
    assign o_reg_field    = r_out.reg_field;
    assign o_rm_field     = r_out.rm_field;
    assign o_displacement = r_out.displacement;
    assign o_immediate    = r_out.immediate;
    assign o_start_offset = r_out.start_offset;
    assign o_length       = r_out.length;

endmodule
